FILE: src/bsf_pkg.sv
// Shared types and codes for the BGP session controller.
// Holds the event and result records, the state, event and message codes
// and the register reset values. No dependencies.
`default_nettype none

package bsf_pkg;

  // Session states
  localparam logic [2:0] ST_IDLE        = 3'd0;
  localparam logic [2:0] ST_CONNECT     = 3'd1;
  localparam logic [2:0] ST_ACTIVE      = 3'd2;
  localparam logic [2:0] ST_OPENSENT    = 3'd3;
  localparam logic [2:0] ST_OPENCONFIRM = 3'd4;
  localparam logic [2:0] ST_ESTABLISHED = 3'd5;

  // Event kinds
  localparam logic [2:0] EV_TICK     = 3'd0;
  localparam logic [2:0] EV_TCP      = 3'd1;
  localparam logic [2:0] EV_MSG      = 3'd2;
  localparam logic [2:0] EV_LINK_ERR = 3'd3;
  localparam logic [2:0] EV_START    = 3'd4;
  localparam logic [2:0] EV_SHUTDOWN = 3'd5;

  // Received message types
  localparam logic [7:0] MT_OPEN      = 8'd1;
  localparam logic [7:0] MT_UPDATE    = 8'd2;
  localparam logic [7:0] MT_NOTIFY    = 8'd3;
  localparam logic [7:0] MT_KEEPALIVE = 8'd4;

  // Messages to send
  localparam logic [1:0] TX_NONE      = 2'd0;
  localparam logic [1:0] TX_OPEN      = 2'd1;
  localparam logic [1:0] TX_KEEPALIVE = 2'd2;
  localparam logic [1:0] TX_NOTIFY    = 2'd3;

  // Notification codes
  localparam logic [7:0] NC_NONE      = 8'd0;
  localparam logic [7:0] NC_OPEN_ERR  = 8'd2;
  localparam logic [7:0] NC_FSM_ERR   = 8'd5;
  localparam logic [7:0] NC_CEASE     = 8'd6;
  localparam logic [7:0] NS_NONE      = 8'd0;
  localparam logic [7:0] NS_BAD_VER   = 8'd1;

  localparam logic [7:0] SUPPORTED_VER = 8'd4;

  // Configuration register indexes and reset values
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_HOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONNECT_RETRY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SESSION_RETRY = 2'd2;
  localparam logic [15:0] LOCAL_HOLD_RST    = 16'd180;
  localparam logic [7:0]  CONNECT_RETRY_RST = 8'd5;
  localparam logic [7:0]  SESSION_RETRY_RST = 8'd10;

  // One event
  typedef struct packed {
    logic [2:0]  kind;
    logic        connect_ok;
    logic        marker_ok;
    logic [7:0]  msg_type;
    logic [7:0]  peer_version;
    logic [15:0] peer_hold_time;
  } item_t;

  // One result
  typedef struct packed {
    logic [2:0]  session_state;
    logic [1:0]  send_msg;
    logic [7:0]  notify_code;
    logic [7:0]  notify_subcode;
    logic        connect_req;
    logic        close_req;
    logic        update_forward;
    logic [15:0] hold_negotiated;
  } result_t;

endpackage

`default_nettype wire

FILE: src/bsf_in_stage.sv
// Input register of the BGP session controller.
// Captures one event per transfer and holds it until the engine takes it.
// Depends on bsf_pkg.
`default_nettype none

module bsf_in_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire bsf_pkg::item_t in_item,
  output logic                in_stall,
  input  wire logic           take,
  output logic                item_valid,
  output bsf_pkg::item_t      item
);

  logic load;
  logic item_valid_next;

  // Stall only while a held event is not taken this cycle
  assign in_stall        = item_valid && !take;
  assign load            = in_valid && !in_stall;
  assign item_valid_next = load || (item_valid && !take);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= item_valid_next;
    end
  end

  // Payload: load on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: src/bsf_engine.sv
// Session state, configuration registers and the per-event transition logic.
// Turns one held event into one result through combinational logic.
// Depends on bsf_pkg.
`default_nettype none

module bsf_engine (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [bsf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bsf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              fire,
  input  wire bsf_pkg::item_t                    item,
  output bsf_pkg::result_t                       res
);

  // Configuration
  logic [15:0] local_hold;
  logic [7:0]  connect_retry;
  logic [7:0]  session_retry;

  // Session state
  logic [2:0]  st;
  logic        running;
  logic [15:0] hold_value;
  logic [14:0] ka_period;
  logic [15:0] tick_count;
  logic [7:0]  retry_count;

  logic [2:0]  st_next;
  logic        running_next;
  logic [15:0] hold_value_next;
  logic [14:0] ka_period_next;
  logic [15:0] tick_count_next;
  logic [7:0]  retry_count_next;

  logic [1:0]  send;
  logic [7:0]  code;
  logic [7:0]  sub;
  logic        conn;
  logic        close;
  logic        upd;

  logic [7:0]  retry_inc;
  logic [15:0] tick_inc;
  logic [15:0] hold_min;
  logic [31:0] div_prod;
  logic [14:0] hold_third;
  logic        in_session;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      local_hold    <= bsf_pkg::LOCAL_HOLD_RST;
      connect_retry <= bsf_pkg::CONNECT_RETRY_RST;
      session_retry <= bsf_pkg::SESSION_RETRY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bsf_pkg::REG_LOCAL_HOLD:    local_hold    <= cfg_data;
        bsf_pkg::REG_CONNECT_RETRY: connect_retry <= cfg_data[7:0];
        bsf_pkg::REG_SESSION_RETRY: session_retry <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Saturating counters, hold negotiation and hold/3 by reciprocal multiply
  assign retry_inc  = (retry_count == 8'hFF) ? 8'hFF : retry_count + 8'd1;
  assign tick_inc   = (tick_count == 16'hFFFF) ? 16'hFFFF : tick_count + 16'd1;
  assign hold_min   = (local_hold < item.peer_hold_time) ? local_hold : item.peer_hold_time;
  assign div_prod   = {16'd0, hold_min} * 32'h0000_AAAB;
  assign hold_third = div_prod[31:17];
  assign in_session = (st == bsf_pkg::ST_OPENSENT) || (st == bsf_pkg::ST_OPENCONFIRM) ||
                      (st == bsf_pkg::ST_ESTABLISHED);

  // Transition for one event
  always_comb begin
    st_next          = st;
    running_next     = running;
    hold_value_next  = hold_value;
    ka_period_next   = ka_period;
    tick_count_next  = tick_count;
    retry_count_next = retry_count;
    send  = bsf_pkg::TX_NONE;
    code  = bsf_pkg::NC_NONE;
    sub   = bsf_pkg::NS_NONE;
    conn  = 1'b0;
    close = 1'b0;
    upd   = 1'b0;

    if (item.kind == bsf_pkg::EV_START) begin
      if (!running) begin
        running_next     = 1'b1;
        tick_count_next  = 16'd0;
        st_next          = bsf_pkg::ST_CONNECT;
        conn             = 1'b1;
        retry_count_next = 8'd0;
      end
    end else if (running) begin
      case (item.kind)
        bsf_pkg::EV_TICK: begin
          if (st == bsf_pkg::ST_IDLE || st == bsf_pkg::ST_ACTIVE) begin
            retry_count_next = retry_inc;
            if (retry_inc >= ((st == bsf_pkg::ST_IDLE) ? session_retry : connect_retry)) begin
              st_next          = bsf_pkg::ST_CONNECT;
              conn             = 1'b1;
              retry_count_next = 8'd0;
            end
          end else if (st == bsf_pkg::ST_ESTABLISHED) begin
            if (tick_inc >= {1'b0, ka_period}) begin
              send            = bsf_pkg::TX_KEEPALIVE;
              tick_count_next = 16'd0;
            end else begin
              tick_count_next = tick_inc;
            end
          end
        end
        bsf_pkg::EV_TCP: begin
          if (st == bsf_pkg::ST_CONNECT) begin
            if (item.connect_ok) begin
              st_next = bsf_pkg::ST_OPENSENT;
              send    = bsf_pkg::TX_OPEN;
            end else begin
              st_next          = bsf_pkg::ST_ACTIVE;
              retry_count_next = 8'd0;
            end
          end
        end
        bsf_pkg::EV_MSG: begin
          if (in_session) begin
            if (!item.marker_ok || item.msg_type == bsf_pkg::MT_NOTIFY) begin
              close = 1'b1;
            end else if (st == bsf_pkg::ST_OPENSENT) begin
              if (item.msg_type != bsf_pkg::MT_OPEN) begin
                send  = bsf_pkg::TX_NOTIFY;
                code  = bsf_pkg::NC_FSM_ERR;
                close = 1'b1;
              end else if (item.peer_version != bsf_pkg::SUPPORTED_VER) begin
                send  = bsf_pkg::TX_NOTIFY;
                code  = bsf_pkg::NC_OPEN_ERR;
                sub   = bsf_pkg::NS_BAD_VER;
                close = 1'b1;
              end else begin
                hold_value_next = hold_min;
                ka_period_next  = (hold_third == 15'd0) ? 15'd1 : hold_third;
                st_next         = bsf_pkg::ST_OPENCONFIRM;
                send            = bsf_pkg::TX_KEEPALIVE;
              end
            end else if (st == bsf_pkg::ST_OPENCONFIRM) begin
              if (item.msg_type == bsf_pkg::MT_KEEPALIVE) begin
                st_next         = bsf_pkg::ST_ESTABLISHED;
                tick_count_next = 16'd0;
              end else if (item.msg_type != bsf_pkg::MT_OPEN) begin
                send  = bsf_pkg::TX_NOTIFY;
                code  = bsf_pkg::NC_FSM_ERR;
                close = 1'b1;
              end
            end else begin
              upd             = (item.msg_type == bsf_pkg::MT_UPDATE);
              send            = bsf_pkg::TX_KEEPALIVE;
              tick_count_next = 16'd0;
            end
          end
        end
        bsf_pkg::EV_LINK_ERR: begin
          close = in_session;
        end
        bsf_pkg::EV_SHUTDOWN: begin
          if (st == bsf_pkg::ST_ESTABLISHED) begin
            send = bsf_pkg::TX_NOTIFY;
            code = bsf_pkg::NC_CEASE;
          end
          running_next = 1'b0;
          close        = 1'b1;
        end
        default: ;
      endcase
    end

    // Drop the session: back to idle, restart both counters
    if (close) begin
      st_next          = bsf_pkg::ST_IDLE;
      retry_count_next = 8'd0;
      tick_count_next  = 16'd0;
    end
  end

  // Advance the session state on each event the output side takes
  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= bsf_pkg::ST_IDLE;
      running     <= 1'b0;
      hold_value  <= 16'd0;
      ka_period   <= 15'd1;
      tick_count  <= 16'd0;
      retry_count <= 8'd0;
    end else if (fire) begin
      st          <= st_next;
      running     <= running_next;
      hold_value  <= hold_value_next;
      ka_period   <= ka_period_next;
      tick_count  <= tick_count_next;
      retry_count <= retry_count_next;
    end
  end

  always_comb begin
    res.session_state   = st_next;
    res.send_msg        = send;
    res.notify_code     = code;
    res.notify_subcode  = sub;
    res.connect_req     = conn;
    res.close_req       = close;
    res.update_forward  = upd;
    res.hold_negotiated = hold_value_next;
  end

  // Checks
  a_reset_idle: assert property (@(posedge clk) rst |=> (st == bsf_pkg::ST_IDLE) && !running)
    else $error("state not idle after reset");

  a_stopped_idle: assert property (@(posedge clk) disable iff (rst)
    !running |-> (st == bsf_pkg::ST_IDLE))
    else $error("session not idle while stopped");

  a_codes_only_with_notify: assert property (@(posedge clk) disable iff (rst)
    (fire && send != bsf_pkg::TX_NOTIFY) |->
      (code == bsf_pkg::NC_NONE && sub == bsf_pkg::NS_NONE))
    else $error("notification codes without a notification");

  a_connect_enters_connect: assert property (@(posedge clk) disable iff (rst)
    (fire && conn) |=> (st == bsf_pkg::ST_CONNECT))
    else $error("connect request without entering connect");

  a_ka_period_nonzero: assert property (@(posedge clk) disable iff (rst)
    ka_period != 15'd0)
    else $error("keepalive period is zero");

endmodule

`default_nettype wire

FILE: src/bsf_out_stage.sv
// Result register of the BGP session controller.
// Holds one result until the receiver takes it; reloads in the same cycle.
// Depends on bsf_pkg.
`default_nettype none

module bsf_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire bsf_pkg::result_t res_in,
  output logic                  ready,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output bsf_pkg::result_t      res_out
);

  logic out_valid_next;

  // Free when empty or when the held result transfers this cycle
  assign ready          = !out_valid || !out_stall;
  assign out_valid_next = load || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // Payload: hold while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

`default_nettype wire

FILE: src/bgp_session_fsm_core.sv
// BGP session controller for one peer: event in, one result out per event.
//
// Input channel (in_valid/in_stall) carries one event: tick, TCP result,
// received message header, link error, admin start or admin shutdown.
// Output channel (out_valid/out_stall) carries one result per event: the
// session state after the event, the message to send, notification codes,
// connect/close requests, update forwarding and the negotiated hold time.
// Configuration writes (cfg_we, cfg_index, cfg_data) set local hold time,
// connect retry and session retry; write only while no event is in flight.
//
// Path: an event moves from the input register through the combinational
// transition logic into the result register. Throughput: one event per cycle
// while the receiver does not stall; the transition logic sets that figure.
// While the receiver stalls, the result holds and one more event is taken
// into the input register; after that in_stall rises.
// Reset (rst, synchronous) empties both registers, puts the session in Idle
// not running, and loads hold 180, connect retry 5, session retry 10.
`default_nettype none

module bgp_session_fsm_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [bsf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bsf_pkg::CFG_DATA_W-1:0]    cfg_data,
  // events
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [2:0]                        kind,
  input  wire logic                              connect_ok,
  input  wire logic                              marker_ok,
  input  wire logic [7:0]                        msg_type,
  input  wire logic [7:0]                        peer_version,
  input  wire logic [15:0]                       peer_hold_time,
  // results
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [2:0]                             session_state,
  output logic [1:0]                             send_msg,
  output logic [7:0]                             notify_code,
  output logic [7:0]                             notify_subcode,
  output logic                                   connect_req,
  output logic                                   close_req,
  output logic                                   update_forward,
  output logic [15:0]                            hold_negotiated
);

  bsf_pkg::item_t   in_item;
  bsf_pkg::item_t   item;
  bsf_pkg::result_t res;
  bsf_pkg::result_t res_out;
  logic             item_valid;
  logic             out_ready;
  logic             fire;

  always_comb begin
    in_item.kind           = kind;
    in_item.connect_ok     = connect_ok;
    in_item.marker_ok      = marker_ok;
    in_item.msg_type       = msg_type;
    in_item.peer_version   = peer_version;
    in_item.peer_hold_time = peer_hold_time;
  end

  // Process the held event when the result register can take it
  assign fire = item_valid && out_ready;

  bsf_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  bsf_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (item),
    .res       (res)
  );

  bsf_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res_in    (res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_out)
  );

  assign session_state   = res_out.session_state;
  assign send_msg        = res_out.send_msg;
  assign notify_code     = res_out.notify_code;
  assign notify_subcode  = res_out.notify_subcode;
  assign connect_req     = res_out.connect_req;
  assign close_req       = res_out.close_req;
  assign update_forward  = res_out.update_forward;
  assign hold_negotiated = res_out.hold_negotiated;

endmodule

`default_nettype wire
